FILE: rtl/nolp_pkg.sv
// Package for the nested option list parser: sizes, codes and the result record.
// Used by every module of the block; has no dependencies of its own.
package nolp_pkg;

  // String and nesting limits
  localparam int MaxLen   = 4096;
  localparam int MaxDepth = 255;

  // Derived widths
  localparam int IdxW   = $clog2(MaxLen);      // character index
  localparam int PosW   = IdxW + 1;            // position / length, can hold MaxLen
  localparam int NestW  = $clog2(MaxDepth + 1);
  localparam int CharW  = 16;

  // Fixed characters treated as whitespace
  localparam logic [CharW-1:0] ChSpace = CharW'(32);
  localparam logic [CharW-1:0] ChTab   = CharW'(9);

  // Reset values of the configuration registers
  localparam logic [CharW-1:0] OpenRst  = CharW'(40);
  localparam logic [CharW-1:0] CloseRst = CharW'(41);
  localparam logic [CharW-1:0] DelimRst = CharW'(32);

  // Result queue sizing
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = QPtrW + 1;

  typedef enum logic [1:0] {
    CFG_OPEN    = 2'd0,
    CFG_CLOSE   = 2'd1,
    CFG_DELIM   = 2'd2,
    CFG_POSTFIX = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_ENTRY   = 3'd0,
    KIND_DONE    = 3'd1,
    KIND_STRAY   = 3'd2,
    KIND_UNEXP   = 3'd3,
    KIND_UNTERM  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    PH_SKIP       = 3'd0,
    PH_NAME       = 3'd1,
    PH_AFTER_NAME = 3'd2,
    PH_ARG        = 3'd3,
    PH_AFTER_ARG  = 3'd4,
    PH_POST       = 3'd5
  } phase_e;

  typedef struct packed {
    kind_e             kind;
    logic [IdxW-1:0]   name_start;
    logic [PosW-1:0]   name_len;
    logic              has_arg;
    logic [IdxW-1:0]   arg_start;
    logic [PosW-1:0]   arg_len;
    logic [IdxW-1:0]   post_start;
    logic [PosW-1:0]   post_len;
    logic              run_last;
  } result_t;

  // Results produced by one accepted character
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

FILE: rtl/nolp_core.sv
// Parser core: configuration registers, per-string state and result generation.
// Depends on nolp_pkg.
module nolp_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  logic [nolp_pkg::CharW-1:0]    ch_i,
  input  logic                          eos_i,
  input  logic                          cfg_we_i,
  input  nolp_pkg::cfg_idx_e            cfg_idx_i,
  input  logic [nolp_pkg::CharW-1:0]    cfg_data_i,
  output nolp_pkg::push_t               push_o
);

  localparam int IdxW  = nolp_pkg::IdxW;
  localparam int PosW  = nolp_pkg::PosW;
  localparam int NestW = nolp_pkg::NestW;
  localparam int CharW = nolp_pkg::CharW;

  // Configuration
  logic [CharW-1:0] open_q, close_q, delim_q;
  logic             postfix_q;

  // String state
  logic [PosW-1:0]     pos_q, pos_d;
  nolp_pkg::phase_e    phase_q, phase_d, cur;
  logic [NestW-1:0]    nest_q, nest_d, nest_t;
  logic [IdxW-1:0]     nstart_q, nstart_d;
  logic [PosW-1:0]     nlen_q, nlen_d;
  logic [IdxW-1:0]     first_q, first_d, last_q, last_d;
  logic                any_q, any_d;
  logic [IdxW-1:0]     sas_q, sas_d;
  logic [PosW-1:0]     sal_q, sal_d;
  logic                err_q, err_d;

  logic [IdxW-1:0]     pos_idx;
  logic                ws, is_open, is_close, is_delim, active, fin;
  logic [1:0]          n;
  nolp_pkg::result_t   res [2];

  function automatic nolp_pkg::result_t mk(
    input nolp_pkg::kind_e k, input logic [IdxW-1:0] ns, input logic [PosW-1:0] nl,
    input logic ha, input logic [IdxW-1:0] as, input logic [PosW-1:0] al,
    input logic [IdxW-1:0] ps, input logic [PosW-1:0] pl);
    nolp_pkg::result_t r;
    r = '0;
    r.kind = k;
    if (k == nolp_pkg::KIND_ENTRY) begin
      r.name_start = ns;
      r.name_len   = nl;
      r.has_arg    = ha;
      r.arg_start  = as;
      r.arg_len    = al;
      r.post_start = ps;
      r.post_len   = pl;
    end
    return r;
  endfunction

  function automatic logic [IdxW-1:0] tstart(input logic any, input logic [IdxW-1:0] f);
    return any ? f : '0;
  endfunction

  function automatic logic [PosW-1:0] tlen(input logic any, input logic [IdxW-1:0] f,
                                           input logic [IdxW-1:0] l);
    return any ? ({1'b0, l} - {1'b0, f} + PosW'(1)) : '0;
  endfunction

  assign pos_idx  = pos_q[IdxW-1:0];
  assign ws       = (ch_i == nolp_pkg::ChSpace) || (ch_i == nolp_pkg::ChTab);
  assign is_open  = (ch_i == open_q);
  assign is_close = (ch_i == close_q);
  assign is_delim = (ch_i == delim_q);
  assign active   = fire_i && !err_q && (pos_q < PosW'(nolp_pkg::MaxLen));

  // Per-character parse step followed by end-of-string handling
  always_comb begin
    pos_d    = pos_q;
    phase_d  = phase_q;
    nest_d   = nest_q;
    nstart_d = nstart_q;
    nlen_d   = nlen_q;
    first_d  = first_q;
    last_d   = last_q;
    any_d    = any_q;
    sas_d    = sas_q;
    sal_d    = sal_q;
    err_d    = err_q;
    cur      = phase_q;
    fin      = 1'b0;
    nest_t   = nest_q;
    n        = 2'd0;
    res[0]   = '0;
    res[1]   = '0;

    if (active) begin
      // leading separators, then the name
      if (cur == nolp_pkg::PH_SKIP) begin
        if (ws || is_delim) begin
          fin = 1'b1;
        end else begin
          nstart_d = pos_idx;
          cur      = nolp_pkg::PH_NAME;
        end
      end
      if (!fin && cur == nolp_pkg::PH_NAME) begin
        if (!(ws || is_open || is_close || is_delim)) begin
          fin = 1'b1;
        end else begin
          nlen_d = pos_q - {1'b0, nstart_d};
          cur    = nolp_pkg::PH_AFTER_NAME;
        end
      end
      if (!fin && cur == nolp_pkg::PH_AFTER_NAME) begin
        fin = 1'b1;
        priority if (ws) begin
        end else if (is_close) begin
          err_d  = 1'b1;
          res[n[0]] = mk(nolp_pkg::KIND_STRAY, '0, '0, 1'b0, '0, '0, '0, '0);
          n = n + 2'd1;
        end else if (is_delim) begin
          cur = nolp_pkg::PH_SKIP;
          res[n[0]] = mk(nolp_pkg::KIND_ENTRY, nstart_d, nlen_d, 1'b0, '0, '0, '0, '0);
          n = n + 2'd1;
        end else if (is_open) begin
          nest_d = NestW'(1);
          any_d  = 1'b0;
          cur    = nolp_pkg::PH_ARG;
        end else begin
          err_d  = 1'b1;
          res[n[0]] = mk(nolp_pkg::KIND_UNEXP, '0, '0, 1'b0, '0, '0, '0, '0);
          n = n + 2'd1;
        end
      end
      if (!fin) begin
        unique case (cur)
          nolp_pkg::PH_ARG: begin
            // nesting count saturates at the top
            if (is_open && nest_t < NestW'(nolp_pkg::MaxDepth)) nest_t = nest_t + NestW'(1);
            if (is_close && nest_t != '0) nest_t = nest_t - NestW'(1);
            nest_d = nest_t;
            if (nest_t == '0) begin
              sas_d = tstart(any_q, first_q);
              sal_d = tlen(any_q, first_q, last_q);
              if (postfix_q) begin
                any_d = 1'b0;
                cur   = nolp_pkg::PH_POST;
              end else begin
                cur = nolp_pkg::PH_AFTER_ARG;
                res[n[0]] = mk(nolp_pkg::KIND_ENTRY, nstart_q, nlen_q, 1'b1,
                               sas_d, sal_d, '0, '0);
                n = n + 2'd1;
              end
            end else if (!ws) begin
              if (!any_q) begin
                first_d = pos_idx;
                any_d   = 1'b1;
              end
              last_d = pos_idx;
            end
          end
          nolp_pkg::PH_AFTER_ARG: begin
            priority if (ws) begin
            end else if (is_delim) begin
              cur = nolp_pkg::PH_SKIP;
            end else begin
              err_d = 1'b1;
              res[n[0]] = mk(nolp_pkg::KIND_UNEXP, '0, '0, 1'b0, '0, '0, '0, '0);
              n = n + 2'd1;
            end
          end
          nolp_pkg::PH_POST: begin
            if (is_open || is_close || is_delim) begin
              res[n[0]] = mk(nolp_pkg::KIND_ENTRY, nstart_q, nlen_q, 1'b1, sas_q, sal_q,
                             tstart(any_q, first_q), tlen(any_q, first_q, last_q));
              n = n + 2'd1;
              if (!is_delim) begin
                err_d = 1'b1;
                res[n[0]] = mk(nolp_pkg::KIND_UNEXP, '0, '0, 1'b0, '0, '0, '0, '0);
                n = n + 2'd1;
              end else begin
                cur = nolp_pkg::PH_SKIP;
              end
            end else if (!ws) begin
              if (!any_q) begin
                first_d = pos_idx;
                any_d   = 1'b1;
              end
              last_d = pos_idx;
            end
          end
          default: begin
          end
        endcase
      end
      phase_d = cur;
      pos_d   = pos_q + PosW'(1);
    end

    // eos: if no error, flush entry, report done/unterm; clear string state
    if (fire_i && eos_i) begin
      if (!err_d) begin
        unique case (phase_d)
          nolp_pkg::PH_NAME: begin
            res[n[0]] = mk(nolp_pkg::KIND_ENTRY, nstart_d, pos_d - {1'b0, nstart_d},
                           1'b0, '0, '0, '0, '0);
            n = n + 2'd1;
          end
          nolp_pkg::PH_AFTER_NAME: begin
            res[n[0]] = mk(nolp_pkg::KIND_ENTRY, nstart_d, nlen_d, 1'b0, '0, '0, '0, '0);
            n = n + 2'd1;
          end
          nolp_pkg::PH_POST: begin
            res[n[0]] = mk(nolp_pkg::KIND_ENTRY, nstart_d, nlen_d, 1'b1, sas_d, sal_d,
                           tstart(any_d, first_d), tlen(any_d, first_d, last_d));
            n = n + 2'd1;
          end
          default: begin
          end
        endcase
        if (phase_d == nolp_pkg::PH_ARG) begin
          res[n[0]] = mk(nolp_pkg::KIND_UNTERM, '0, '0, 1'b0, '0, '0, '0, '0);
        end else begin
          res[n[0]] = mk(nolp_pkg::KIND_DONE, '0, '0, 1'b0, '0, '0, '0, '0);
        end
        n = n + 2'd1;
      end
      pos_d    = '0;
      phase_d  = nolp_pkg::PH_SKIP;
      nest_d   = '0;
      nstart_d = '0;
      nlen_d   = '0;
      first_d  = '0;
      last_d   = '0;
      any_d    = 1'b0;
      sas_d    = '0;
      sal_d    = '0;
      err_d    = 1'b0;
    end

    // mark the final result of this character
    if (n == 2'd1) res[0].run_last = 1'b1;
    if (n == 2'd2) res[1].run_last = 1'b1;
  end

  assign push_o.cnt = n;
  assign push_o.r0  = res[0];
  assign push_o.r1  = res[1];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q    <= nolp_pkg::OpenRst;
      close_q   <= nolp_pkg::CloseRst;
      delim_q   <= nolp_pkg::DelimRst;
      postfix_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nolp_pkg::CFG_OPEN:    open_q    <= cfg_data_i;
        nolp_pkg::CFG_CLOSE:   close_q   <= cfg_data_i;
        nolp_pkg::CFG_DELIM:   delim_q   <= cfg_data_i;
        nolp_pkg::CFG_POSTFIX: postfix_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // String state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      phase_q  <= nolp_pkg::PH_SKIP;
      nest_q   <= '0;
      nstart_q <= '0;
      nlen_q   <= '0;
      first_q  <= '0;
      last_q   <= '0;
      any_q    <= 1'b0;
      sas_q    <= '0;
      sal_q    <= '0;
      err_q    <= 1'b0;
    end else if (fire_i) begin
      pos_q    <= pos_d;
      phase_q  <= phase_d;
      nest_q   <= nest_d;
      nstart_q <= nstart_d;
      nlen_q   <= nlen_d;
      first_q  <= first_d;
      last_q   <= last_d;
      any_q    <= any_d;
      sas_q    <= sas_d;
      sal_q    <= sal_d;
      err_q    <= err_d;
    end
  end

endmodule

FILE: rtl/nolp_queue.sv
// Result queue: takes up to two results per cycle, hands out one per transaction.
// Depends on nolp_pkg.
module nolp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nolp_pkg::push_t   push_i,
  input  logic              pop_i,
  output nolp_pkg::result_t head_o,
  output logic              not_empty_o,
  output logic              full_o
);

  localparam int PtrW = nolp_pkg::QPtrW;
  localparam int CntW = nolp_pkg::QCntW;

  nolp_pkg::result_t  mem_q [nolp_pkg::QDepth];
  logic [PtrW-1:0]    wr_q, rd_q;
  logic [CntW-1:0]    cnt_q;
  logic [PtrW-1:0]    wr_nxt;

  assign wr_nxt      = wr_q + PtrW'(1);
  assign head_o      = mem_q[rd_q];
  assign not_empty_o = (cnt_q != '0);
  // no room for two more results
  assign full_o      = (cnt_q > CntW'(nolp_pkg::QDepth - 2));

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wr_q]   <= push_i.r0;
    if (push_i.cnt == 2'd2) mem_q[wr_nxt] <= push_i.r1;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(push_i.cnt);
      rd_q  <= rd_q + PtrW'(pop_i);
      cnt_q <= cnt_q + CntW'(push_i.cnt) - CntW'(pop_i);
    end
  end

endmodule

FILE: rtl/nested_option_list_parser.sv
// Top level of the nested option list parser: ports, handshakes, core and queue.
// Depends on nolp_pkg, nolp_core and nolp_queue.
//
// Usage
//   Input channel: one character per transaction (ch_i, end_of_string_i),
//   accepted when in_valid_i is high and in_stall_o is low.
//   Output channel: one result per transaction (kind_o and the span fields),
//   taken when out_valid_o is high and out_stall_i is low. run_last_o marks
//   the last result caused by one character.
//   Config channel: cfg_index_i selects open, close, delimiter or postfix
//   mode; always ready. Write only while no string is in flight.
// Timing
//   A result is registered in the queue before it reaches the output. One
//   character per cycle is accepted while in_stall_o is low; characters that
//   cause two results need two output transactions. The four-entry result
//   queue sets the limit: in_stall_o rises once more than two results are queued.
// Reset and stall
//   Reset clears parse state and the queue and restores the default
//   characters. While the receiver stalls, the head result holds and the
//   input stalls once the queue is near full.
module nested_option_list_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] ch_i,
  input  logic        end_of_string_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [11:0] name_start_o,
  output logic [12:0] name_len_o,
  output logic        has_arg_o,
  output logic [11:0] arg_start_o,
  output logic [12:0] arg_len_o,
  output logic [11:0] post_start_o,
  output logic [12:0] post_len_o,
  output logic        run_last_o
);

  nolp_pkg::push_t   push;
  nolp_pkg::result_t head;
  logic              fire, full, not_empty;

  assign fire        = in_valid_i && !in_stall_o;
  assign in_stall_o  = full;
  assign cfg_ready_o = 1'b1;

  nolp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .ch_i       (ch_i),
    .eos_i      (end_of_string_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_idx_i  (nolp_pkg::cfg_idx_e'(cfg_index_i)),
    .cfg_data_i (cfg_data_i),
    .push_o     (push)
  );

  nolp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .pop_i       (not_empty && !out_stall_i),
    .head_o      (head),
    .not_empty_o (not_empty),
    .full_o      (full)
  );

  // Output fields straight from the queue head
  assign out_valid_o  = not_empty;
  assign kind_o       = head.kind;
  assign name_start_o = head.name_start;
  assign name_len_o   = head.name_len;
  assign has_arg_o    = head.has_arg;
  assign arg_start_o  = head.arg_start;
  assign arg_len_o    = head.arg_len;
  assign post_start_o = head.post_start;
  assign post_len_o   = head.post_len;
  assign run_last_o   = head.run_last;

endmodule

FILE: rtl/nolp_checker.sv
// Port-level checks for the nested option list parser, bound to the top level.
// Depends on nolp_pkg and nested_option_list_parser.
module nolp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  kind_o,
  input logic [11:0] name_start_o,
  input logic [12:0] name_len_o,
  input logic        has_arg_o,
  input logic [11:0] arg_start_o,
  input logic [12:0] arg_len_o,
  input logic [12:0] post_len_o,
  input logic        run_last_o
);

  // A stalled result stays offered
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its contents
  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(kind_o) && $stable(name_len_o)
      && $stable(arg_len_o) && $stable(run_last_o))
    else $error("result changed while stalled");

  // Non-entry results carry no spans
  a_nonentry_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != nolp_pkg::KIND_ENTRY |->
      name_start_o == '0 && name_len_o == '0 && !has_arg_o && post_len_o == '0)
    else $error("span fields set on non-entry result");

  // Status and error results end the run of one character
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != nolp_pkg::KIND_ENTRY |-> run_last_o)
    else $error("status result not last of its character");

  // Entries without an argument have an empty argument span
  a_noarg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == nolp_pkg::KIND_ENTRY && !has_arg_o |->
      arg_start_o == '0 && arg_len_o == '0)
    else $error("argument span set on entry without argument");

endmodule

bind nested_option_list_parser nolp_checker u_nolp_checker (.*);
